/* rtl/wvosc_pkg.sv */
// ----------------------------------------------------------------------------
// Waveform oscillator package
// Shared widths, the waveform codes, the scale operation codes and the operand
// record that the operand stage hands to the scale stage.
// ----------------------------------------------------------------------------
package wvosc_pkg;

  localparam int unsigned MODE_W   = 3;
  localparam int unsigned PHASE_W  = 31;
  localparam int unsigned FRAC_W   = 16;
  localparam int unsigned SAMPLE_W = 18;
  localparam int unsigned X_W      = 20;

  typedef enum logic [MODE_W-1:0] {
    WAVE_TRIANGLE = 3'd0,
    WAVE_TILT_SAW = 3'd1,
    WAVE_SAW      = 3'd2,
    WAVE_SQUARE   = 3'd3,
    WAVE_PULSE    = 3'd4,
    WAVE_ORGAN    = 3'd5,
    WAVE_NOISE    = 3'd6,
    WAVE_PHASER   = 3'd7
  } wave_e;

  typedef enum logic [2:0] {
    OP_DIRECT,
    OP_TILT_LO,
    OP_TILT_HI,
    OP_SAW,
    OP_DIV9,
    OP_DIV6
  } op_e;

  typedef struct packed {
    op_e                         op;
    logic                        neg;
    logic signed [X_W-1:0]       x;
    logic signed [SAMPLE_W-1:0]  direct;
  } operand_t;

endpackage

/* rtl/wvosc_prep.sv */
// ----------------------------------------------------------------------------
// Waveform oscillator operand stage
// Per waveform, forms either the final sample or a magnitude, sign and scale
// operation for the multiply stage, and registers it.
// ----------------------------------------------------------------------------
module wvosc_prep import wvosc_pkg::*; (
  input  logic               clk_i,
  input  logic               load_i,
  input  logic [MODE_W-1:0]  mode_i,
  input  logic [PHASE_W-1:0] phase_i,
  output operand_t           operand_o
);

  localparam int unsigned MOD_SHIFT = 7;
  localparam logic [FRAC_W-1:0] TILT_PEAK   = 16'd58982;
  localparam logic [FRAC_W-1:0] PULSE_SPLIT = 16'd21843;
  localparam logic signed [SAMPLE_W-1:0] QUARTER = 18'sd16384;

  wave_e                   wave;
  logic [FRAC_W-1:0]       t;
  logic [FRAC_W-1:0]       s;

  logic signed [17:0]      tri_lin;
  logic [16:0]             tri_abs;
  logic signed [17:0]      tri_val;

  logic signed [21:0]      org_lin;
  logic signed [21:0]      org_abs;
  logic signed [21:0]      org_r;

  logic signed [17:0]      k_lin;
  logic [16:0]             k_abs;
  logic [FRAC_W-1:0]       u;
  logic signed [18:0]      pa_lin;
  logic [17:0]             pa_abs;
  logic signed [19:0]      pb_lin;
  logic [18:0]             pb_abs;
  logic signed [19:0]      ph_r;

  operand_t                operand_d;
  operand_t                operand_q;

  assign wave = wave_e'(mode_i);
  assign t    = phase_i[FRAC_W-1:0];
  assign s    = phase_i[FRAC_W+MOD_SHIFT-1:MOD_SHIFT];

  always_comb begin
    tri_lin = $signed({1'b0, t, 1'b0}) - 18'sd65536;
    tri_abs = tri_lin[17] ? 17'(-tri_lin) : 17'(tri_lin);
    tri_val = $signed({1'b0, tri_abs}) - 18'sd32768;

    if (t[FRAC_W-1]) begin
      org_lin = $signed({2'b00, t, 4'b0000}) - 22'sd786432;
    end else begin
      org_lin = $signed({6'd0, t}) * 22'sd24 - 22'sd393216;
    end
    org_abs = org_lin[21] ? -org_lin : org_lin;
    org_r   = (t[FRAC_W-1] ? 22'sd65536 : 22'sd196608) - org_abs;

    k_lin  = $signed({1'b0, s, 1'b0}) - 18'sd65536;
    k_abs  = k_lin[17] ? 17'(-k_lin) : 17'(k_lin);
    u      = t + k_abs[16:1];
    pa_lin = $signed({1'b0, u, 2'b00}) - 19'sd131072;
    pa_abs = pa_lin[18] ? 18'(-pa_lin) : 18'(pa_lin);
    pb_lin = $signed({1'b0, t, 3'b000}) - 20'sd262144;
    pb_abs = pb_lin[19] ? 19'(-pb_lin) : 19'(pb_lin);
    ph_r   = $signed({2'b00, pa_abs}) - $signed({1'b0, pb_abs});
  end

  always_comb begin
    operand_d.op     = OP_DIRECT;
    operand_d.neg    = 1'b0;
    operand_d.x      = '0;
    operand_d.direct = '0;
    unique case (wave)
      WAVE_TRIANGLE: operand_d.direct = tri_val;
      WAVE_TILT_SAW: begin
        if (t < TILT_PEAK) begin
          operand_d.op = OP_TILT_LO;
          operand_d.x  = $signed({{(X_W-FRAC_W){1'b0}}, t});
        end else begin
          operand_d.op = OP_TILT_HI;
          operand_d.x  = $signed(X_W'(17'd65536 - {1'b0, t}));
        end
      end
      WAVE_SAW: begin
        operand_d.op = OP_SAW;
        operand_d.x  = $signed({{(X_W-FRAC_W){t[FRAC_W-1]}}, t});
      end
      WAVE_SQUARE: operand_d.direct = t[FRAC_W-1] ? -QUARTER : QUARTER;
      WAVE_PULSE:  operand_d.direct = (t < PULSE_SPLIT) ? QUARTER : -QUARTER;
      WAVE_ORGAN: begin
        operand_d.op  = OP_DIV9;
        operand_d.neg = org_r[21];
        operand_d.x   = org_r[21] ? X_W'(-org_r) : X_W'(org_r);
      end
      WAVE_PHASER: begin
        operand_d.op  = OP_DIV6;
        operand_d.neg = ph_r[19];
        operand_d.x   = ph_r[19] ? -ph_r : ph_r;
      end
      WAVE_NOISE: operand_d.direct = '0;
      default:    operand_d.direct = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      operand_q <= operand_d;
    end
  end

  assign operand_o = operand_q;

endmodule

/* rtl/wvosc_scale.sv */
// ----------------------------------------------------------------------------
// Waveform oscillator scale stage
// One shared multiply by a gain or reciprocal constant, a fixed shift per
// operation and the final offset or sign, into the result register.
// ----------------------------------------------------------------------------
module wvosc_scale import wvosc_pkg::*; (
  input  logic                        clk_i,
  input  logic                        load_i,
  input  operand_t                    operand_i,
  output logic signed [SAMPLE_W-1:0]  sample_o
);

  localparam int unsigned MUL_W  = 34;
  localparam int unsigned PROD_W = X_W + MUL_W;
  localparam int unsigned Q_W    = SAMPLE_W + 1;

  // Reciprocals are ceil(2^(K+16)/d) or ceil(2^K/d); K is large enough for
  // an exact floor over each operand range.
  localparam int unsigned TILT_LO_SHIFT = 31;
  localparam int unsigned TILT_HI_SHIFT = 25;
  localparam int unsigned SAW_SHIFT     = 16;
  localparam int unsigned DIV_SHIFT     = 22;

  localparam logic [63:0] TILT_LO_DEN = 64'd29491;
  localparam logic [63:0] TILT_HI_DEN = 64'd3277;
  localparam logic [63:0] ORGAN_DEN   = 64'd9;
  localparam logic [63:0] PHASER_DEN  = 64'd6;

  localparam logic [63:0] TILT_LO_MUL =
    ((64'd1 << (TILT_LO_SHIFT + FRAC_W)) + TILT_LO_DEN - 64'd1) / TILT_LO_DEN;
  localparam logic [63:0] TILT_HI_MUL =
    ((64'd1 << (TILT_HI_SHIFT + FRAC_W)) + TILT_HI_DEN - 64'd1) / TILT_HI_DEN;
  localparam logic [63:0] ORGAN_MUL =
    ((64'd1 << DIV_SHIFT) + ORGAN_DEN - 64'd1) / ORGAN_DEN;
  localparam logic [63:0] PHASER_MUL =
    ((64'd1 << DIV_SHIFT) + PHASER_DEN - 64'd1) / PHASER_DEN;
  localparam logic [63:0] SAW_MUL = 64'd42795;

  logic signed [MUL_W-1:0]    mul_k;
  logic signed [PROD_W-1:0]   prod;
  logic signed [PROD_W-1:0]   quo;
  logic signed [Q_W-1:0]      q;
  logic signed [Q_W-1:0]      tilt_r;
  logic signed [SAMPLE_W-1:0] sample_d;
  logic signed [SAMPLE_W-1:0] sample_q;

  always_comb begin
    unique case (operand_i.op)
      OP_TILT_LO: mul_k = MUL_W'(TILT_LO_MUL);
      OP_TILT_HI: mul_k = MUL_W'(TILT_HI_MUL);
      OP_SAW:     mul_k = MUL_W'(SAW_MUL);
      OP_DIV9:    mul_k = MUL_W'(ORGAN_MUL);
      OP_DIV6:    mul_k = MUL_W'(PHASER_MUL);
      default:    mul_k = '0;
    endcase
  end

  assign prod = PROD_W'(operand_i.x) * PROD_W'(mul_k);

  always_comb begin
    unique case (operand_i.op)
      OP_TILT_LO: quo = prod >>> TILT_LO_SHIFT;
      OP_TILT_HI: quo = prod >>> TILT_HI_SHIFT;
      OP_SAW:     quo = prod >>> SAW_SHIFT;
      OP_DIV9,
      OP_DIV6:    quo = prod >>> DIV_SHIFT;
      default:    quo = '0;
    endcase
    q      = quo[Q_W-1:0];
    tilt_r = q - 19'sd65536;

    unique case (operand_i.op)
      OP_TILT_LO,
      OP_TILT_HI: sample_d = SAMPLE_W'(tilt_r >>> 1);
      OP_SAW:     sample_d = SAMPLE_W'(q);
      OP_DIV9,
      OP_DIV6:    sample_d = operand_i.neg ? SAMPLE_W'(-q) : SAMPLE_W'(q);
      default:    sample_d = operand_i.direct;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      sample_q <= sample_d;
    end
  end

  assign sample_o = sample_q;

endmodule

/* rtl/fixed_point_waveform_oscillator.sv */
// ----------------------------------------------------------------------------
// Fixed-point waveform oscillator
// Stateless per-sample waveform generator, 15.16 phase in, 2.16 sample out.
// ----------------------------------------------------------------------------
// Input channel: in_valid_i/in_ready_o with mode_i (waveform select) and
// phase_i (unsigned 15.16). Output channel: out_valid_o/out_ready_i with
// sample_o (signed 2.16, within plus or minus one).
// Three register stages: input register, operand register (waveform shaping
// and sign split), result register (one shared constant multiply and shift).
// An accepted transaction passes the input, operand and result registers in
// order to sample_o. Throughput is one transaction per cycle while the
// receiver accepts; the multiply stage sets the cycle time.
// Each stage advances when it is empty or the stage behind it advances, so
// a stalled receiver holds the result register while bubbles upstream still
// fill; in_ready_o drops only when all three stages hold transactions.
// Reset clears the three valid bits; no transaction is in flight afterwards
// and in_ready_o is high.
// ----------------------------------------------------------------------------
module fixed_point_waveform_oscillator import wvosc_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [MODE_W-1:0]           mode_i,
  input  logic [PHASE_W-1:0]          phase_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [SAMPLE_W-1:0]  sample_o
);

  logic               v0_q, v1_q, v2_q;
  logic               ready0, ready1, ready2;
  logic [MODE_W-1:0]  mode_q;
  logic [PHASE_W-1:0] phase_q;
  operand_t           operand;

  assign ready2 = !v2_q || out_ready_i;
  assign ready1 = !v1_q || ready2;
  assign ready0 = !v0_q || ready1;

  assign in_ready_o  = ready0;
  assign out_valid_o = v2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (ready0) v0_q <= in_valid_i;
      if (ready1) v1_q <= v0_q;
      if (ready2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && ready0) begin
      mode_q  <= mode_i;
      phase_q <= phase_i;
    end
  end

  wvosc_prep u_prep (
    .clk_i     (clk_i),
    .load_i    (v0_q && ready1),
    .mode_i    (mode_q),
    .phase_i   (phase_q),
    .operand_o (operand)
  );

  wvosc_scale u_scale (
    .clk_i     (clk_i),
    .load_i    (v1_q && ready2),
    .operand_i (operand),
    .sample_o  (sample_o)
  );

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (v0_q && v1_q && v2_q))
    else $error("input stalled with a free stage");

  a_stage0_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v0_q && ready1) |=> v1_q)
    else $error("transaction lost between input and operand stage");

  a_stage1_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && ready2) |=> v2_q)
    else $error("transaction lost between operand and result stage");

  a_stage0_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v0_q && !ready1) |=> v0_q)
    else $error("blocked input stage dropped its transaction");

  a_sample_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q |-> (sample_o >= -18'sd65536 && sample_o <= 18'sd65536))
    else $error("sample outside plus or minus one");

endmodule
